// ----- rtl/rspe_pkg.sv -----
package rspe_pkg;

    localparam int SYMBOL_BITS_DEF  = 8;
    localparam int PARITY_COUNT_DEF = 16;
    localparam int FIRST_ROOT_DEF   = 1;
    localparam int ROOT_STEP_DEF    = 1;
    localparam int PARITY_CAP       = 64;

    localparam int FIELD_W = 8;
    localparam int INDEX_W = 4;

    localparam logic [FIELD_W-1:0] DATA_COUNT_RESET = 8'd239;

    // primitive field polynomials by symbol size
    localparam logic [8:0] FIELD_POLY_3 = 9'o013;
    localparam logic [8:0] FIELD_POLY_4 = 9'o023;
    localparam logic [8:0] FIELD_POLY_5 = 9'o045;
    localparam logic [8:0] FIELD_POLY_6 = 9'o103;
    localparam logic [8:0] FIELD_POLY_7 = 9'o211;
    localparam logic [8:0] FIELD_POLY_8 = 9'o435;

    localparam logic [7:0] GF_ALPHA = 8'd2;

    typedef logic [PARITY_CAP:0][7:0] coef_arr_t;

    function automatic logic [8:0] field_poly(input int bits);
        logic [8:0] p;
        case (bits)
            3: p = FIELD_POLY_3;
            4: p = FIELD_POLY_4;
            5: p = FIELD_POLY_5;
            6: p = FIELD_POLY_6;
            7: p = FIELD_POLY_7;
            8: p = FIELD_POLY_8;
            default: p = FIELD_POLY_8;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input int bits);
        logic [8:0] r;
        logic [8:0] poly;
        r    = '0;
        poly = field_poly(bits);
        for (int k = 7; k >= 0; k--) begin
            if (k < bits) begin
                r = r << 1;
                if (r[bits]) begin
                    r = r ^ poly;
                end
                if (b[k]) begin
                    r = r ^ {1'b0, a};
                end
            end
        end
        return r[7:0];
    endfunction

    // g(x) = prod (x + beta^(first+i)), beta = alpha^step
    function automatic coef_arr_t gen_poly(input int bits, input int count,
                                           input int first, input int step);
        coef_arr_t  g;
        logic [7:0] beta;
        logic [7:0] root;
        g    = '0;
        beta = 8'd1;
        root = 8'd1;
        for (int n = 0; n < step; n++) begin
            beta = gf_mul(beta, GF_ALPHA, bits);
        end
        for (int n = 0; n < first; n++) begin
            root = gf_mul(root, beta, bits);
        end
        g[0] = 8'd1;
        for (int i = 0; i < count; i++) begin
            g[i+1] = g[i];
            for (int j = PARITY_CAP; j > 0; j--) begin
                if (j <= i) begin
                    g[j] = g[j-1] ^ gf_mul(g[j], root, bits);
                end
            end
            g[0] = gf_mul(g[0], root, bits);
            root = gf_mul(root, beta, bits);
        end
        return g;
    endfunction

endpackage

// ----- rtl/rspe_lfsr.sv -----
module rspe_lfsr
    import rspe_pkg::*;
#(
    parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF,
    parameter int PARITY_COUNT = PARITY_COUNT_DEF,
    parameter int FIRST_ROOT   = FIRST_ROOT_DEF,
    parameter int ROOT_STEP    = ROOT_STEP_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic                   clear,
    input  logic [SYMBOL_BITS-1:0] symbol,
    output logic [SYMBOL_BITS-1:0] rem_next [PARITY_COUNT]
);

    localparam coef_arr_t GEN = gen_poly(SYMBOL_BITS, PARITY_COUNT, FIRST_ROOT, ROOT_STEP);

    logic [SYMBOL_BITS-1:0] rem_reg [PARITY_COUNT];
    logic [SYMBOL_BITS-1:0] fb;
    logic [7:0]             fb_wide;

    assign fb      = symbol ^ rem_reg[PARITY_COUNT-1];
    assign fb_wide = 8'(fb);

    always_comb begin
        logic [7:0] prod;
        for (int i = 0; i < PARITY_COUNT; i++) begin
            prod = gf_mul(fb_wide, GEN[i], SYMBOL_BITS);
            if (i == 0) begin
                rem_next[i] = prod[SYMBOL_BITS-1:0];
            end else begin
                rem_next[i] = rem_reg[i-1] ^ prod[SYMBOL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PARITY_COUNT; i++) begin
                rem_reg[i] <= '0;
            end
        end else if (step) begin
            for (int i = 0; i < PARITY_COUNT; i++) begin
                rem_reg[i] <= clear ? '0 : rem_next[i];
            end
        end
    end

endmodule

// ----- rtl/rspe_out_buf.sv -----
module rspe_out_buf
    import rspe_pkg::*;
#(
    parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF,
    parameter int PARITY_COUNT = PARITY_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [SYMBOL_BITS-1:0] load_data [PARITY_COUNT],
    output logic                   busy,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FIELD_W-1:0]     m_parity_symbol,
    output logic [INDEX_W-1:0]     m_parity_index,
    output logic                   m_last_parity
);

    localparam int IDX_W = (PARITY_COUNT > 1) ? $clog2(PARITY_COUNT) : 1;

    logic [SYMBOL_BITS-1:0] par_reg [PARITY_COUNT];
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   take;
    logic                   last;
    logic [IDX_W+INDEX_W-1:0]       idx_wide;
    logic [SYMBOL_BITS+FIELD_W-1:0] sym_wide;

    assign take = valid_reg && m_ready;
    assign last = (idx_reg == IDX_W'(PARITY_COUNT - 1));

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = '0;
            valid_next = 1'b1;
        end else if (take) begin
            idx_next   = idx_reg + 1'b1;
            valid_next = !last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < PARITY_COUNT; i++) begin
                par_reg[i] <= load_data[i];
            end
        end else if (take) begin
            for (int i = 0; i < PARITY_COUNT - 1; i++) begin
                par_reg[i] <= par_reg[i+1];
            end
        end
    end

    assign idx_wide = {{INDEX_W{1'b0}}, idx_reg};
    assign sym_wide = {{FIELD_W{1'b0}}, par_reg[0]};

    assign busy            = valid_reg;
    assign m_valid         = valid_reg;
    assign m_parity_symbol = sym_wide[FIELD_W-1:0];
    assign m_parity_index  = idx_wide[INDEX_W-1:0];
    assign m_last_parity   = last;

`ifndef ASSERT_OFF
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && last) |=> !valid_reg)
        else $error("buffer still valid after last parity beat");
`endif

endmodule

// ----- rtl/reed_solomon_parity_encoder.sv -----
// Reed-Solomon parity encoder, GF(2^SYMBOL_BITS), systematic code.
// Input channel s_*: one data symbol per beat, highest order first.
// Output channel m_*: PARITY_COUNT parity beats per code block, lowest
// order first, with m_parity_index on every beat and m_last_parity on the final beat.
// cfg_wr_en/cfg_wr_data set data_count (k); write only while idle.
// Throughput: one data symbol per cycle while s_ready is high; the remainder
// bank updates in a single parallel step through constant GF multipliers.
// Latency: the first parity beat is valid the cycle after the last data
// beat of the block is accepted; the rest follow one per cycle while m_ready is high.
// The parity is copied into an output shift register when a block ends,
// so the next block's data is taken while parity drains. Only the final
// data beat of a block waits (s_ready low) while the previous block's
// parity is still draining; that buffer sets how often blocks may end.
// A stalled receiver holds m_* steady and, through that, the final beat.
// Reset (aresetn low, synchronous) clears the remainder, the symbol count
// and the output buffer's valid flag and index, and sets data_count to 239.
module reed_solomon_parity_encoder
    import rspe_pkg::*;
#(
    parameter int SYMBOL_BITS  = SYMBOL_BITS_DEF,
    parameter int PARITY_COUNT = PARITY_COUNT_DEF,
    parameter int FIRST_ROOT   = FIRST_ROOT_DEF,
    parameter int ROOT_STEP    = ROOT_STEP_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [FIELD_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_data_symbol,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_parity_symbol,
    output logic [INDEX_W-1:0] m_parity_index,
    output logic               m_last_parity
);

    logic [FIELD_W-1:0]     data_count_reg;
    logic [FIELD_W-1:0]     seen_reg;
    logic [FIELD_W-1:0]     seen_next;
    logic [FIELD_W-1:0]     limit;
    logic                   finish_now;
    logic                   accept;
    logic                   buf_busy;
    logic [SYMBOL_BITS-1:0] rem_next [PARITY_COUNT];

    assign limit      = (data_count_reg == '0) ? FIELD_W'(1) : data_count_reg;
    assign finish_now = ({1'b0, seen_reg} + 9'd1) >= {1'b0, limit};
    assign s_ready    = !(finish_now && buf_busy);
    assign accept     = s_valid && s_ready;

    always_comb begin
        seen_next = seen_reg;
        if (accept) begin
            seen_next = finish_now ? '0 : seen_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_count_reg <= DATA_COUNT_RESET;
            seen_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                data_count_reg <= cfg_wr_data;
            end
            seen_reg <= seen_next;
        end
    end

    rspe_lfsr #(
        .SYMBOL_BITS  (SYMBOL_BITS),
        .PARITY_COUNT (PARITY_COUNT),
        .FIRST_ROOT   (FIRST_ROOT),
        .ROOT_STEP    (ROOT_STEP)
    ) u_lfsr (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .clear    (finish_now),
        .symbol   (s_data_symbol[SYMBOL_BITS-1:0]),
        .rem_next (rem_next)
    );

    rspe_out_buf #(
        .SYMBOL_BITS  (SYMBOL_BITS),
        .PARITY_COUNT (PARITY_COUNT)
    ) u_out_buf (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (accept && finish_now),
        .load_data       (rem_next),
        .busy            (buf_busy),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parity_symbol (m_parity_symbol),
        .m_parity_index  (m_parity_index),
        .m_last_parity   (m_last_parity)
    );

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no parity pending");
    a_block_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && finish_now) |=> (m_valid && m_parity_index == '0))
        else $error("block end did not start parity output");
    a_start_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(accept && finish_now))
        else $error("parity output started without a block end");
`endif

endmodule
